// ===== rtl/bad_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bad_pkg: shared types and constants of the block average downscaler
// Sizes, register indexes, mode codes, sequencer states, divider bundles.
// ----------------------------------------------------------------------------
package bad_pkg;

    localparam int MAX_OUT_W  = 1024;
    localparam int MAX_FACTOR = 16;
    localparam int ACC_DEPTH  = 2 * MAX_OUT_W;
    localparam int ACC_AW     = $clog2(ACC_DEPTH);
    localparam int SUM_W      = 16;
    localparam int ACC_W      = 3 * SUM_W;
    localparam int DIV_W      = 16;
    localparam int FACT_W     = 5;
    localparam int COL_W      = 11;
    localparam int ROW_W      = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] REG_SRC_W  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_H  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_W  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_H  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FORMAT = 3'd4;

    localparam logic [1:0] MODE_COLOR = 2'd0;
    localparam logic [1:0] MODE_GREY  = 2'd1;
    localparam logic [1:0] MODE_RAW   = 2'd2;

    // setup sequence steps
    localparam logic [2:0] STEP_FW  = 3'd0;
    localparam logic [2:0] STEP_FH  = 3'd1;
    localparam logic [2:0] STEP_DW  = 3'd2;
    localparam logic [2:0] STEP_DH  = 3'd3;
    localparam logic [2:0] STEP_COL = 3'd4;
    localparam logic [2:0] STEP_ROW = 3'd5;

    typedef enum logic [2:0] {
        ST_SETUP_GO,
        ST_SETUP_WAIT,
        ST_SETUP_FIN,
        ST_IDLE,
        ST_RMW,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_OUT
    } bad_state_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quot;
        logic [DIV_W-1:0] rem;
    } div_rsp_t;

endpackage

// ===== rtl/bad_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bad_if: stream interfaces of the downscaler
// Source pixel words, result words and configuration writes.
// ----------------------------------------------------------------------------
interface bad_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_c0;
    logic [7:0] pixel_c1;
    logic [7:0] pixel_c2;
    logic       frame_start;
    modport source (output valid, pixel_c0, pixel_c1, pixel_c2, frame_start, input ready);
    modport sink (input valid, pixel_c0, pixel_c1, pixel_c2, frame_start, output ready);
endinterface

interface bad_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_c0;
    logic [7:0] out_c1;
    logic [7:0] out_c2;
    logic       frame_end;
    modport source (output valid, out_c0, out_c1, out_c2, frame_end, input ready);
    modport sink (input valid, out_c0, out_c1, out_c2, frame_end, output ready);
endinterface

interface bad_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [12:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/block_average_image_downscaler_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_average_image_downscaler_core: box-filter image decimator
// Averages factor-by-factor source blocks into output pixels, raster order.
// ----------------------------------------------------------------------------
// Usage:
//  - pix_in (sink): source pixel words in raster order; frame_start puts the
//    word at column 0 of row 0. Position also wraps at the frame size.
//  - res_out (source): one averaged word per completed block, frame_end on
//    the last output pixel of the frame.
//  - cfg (sink): register writes (0 src width, 1 src height, 2 out width,
//    3 out height, 4 format). Each write starts a setup pass that derives
//    factors, covered size and the current block position; pix_in and cfg
//    are not ready during it. Reset runs it.
//  - Column sums live in a 2048 x 48 accumulator RAM (registered read);
//    each word is a read-modify-write.
//  - A word that completes a block then runs the shared bit-serial divider
//    once per channel: 1 channel in grey/raw, 3 in colour mode.
//  - The result sits in an output register; the next pixel is accepted
//    while it waits. A stalled receiver only blocks once another result is
//    ready to be written.
// ----------------------------------------------------------------------------
module block_average_image_downscaler_core import bad_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    bad_pix_if.sink   pix_in,
    bad_res_if.source res_out,
    bad_cfg_if.sink   cfg
);

    bad_state_t state_reg, state_next;

    // configuration
    logic [COL_W-1:0] sw_reg;
    logic [ROW_W-1:0] sh_reg;
    logic [COL_W-1:0] ow_reg;
    logic [ROW_W-1:0] oh_reg;
    logic [1:0]       mode_reg;

    // derived sizes
    logic [FACT_W-1:0] fw_reg, fh_reg;
    logic [COL_W-1:0]  dw_reg, owe_reg;
    logic [ROW_W-1:0]  dh_reg, ohe_reg;
    logic [8:0]        area_reg;

    // position of next pixel: column/row, offset in block, block index
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [FACT_W-1:0] mc_reg, mc_next, mr_reg, mr_next;
    logic [COL_W-1:0]  qc_reg, qc_next;
    logic [ROW_W-1:0]  qr_reg, qr_next;

    // item in flight
    logic [7:0]        pix_reg [3];
    logic              first_reg, last_reg, hit_reg, fe_reg;
    logic [ACC_AW-1:0] idx_reg;
    logic [SUM_W-1:0]  sum_reg [3];
    logic [1:0]        ch_reg;
    logic [7:0]        q_reg [3];
    logic [2:0]        step_reg;

    // output register
    logic       out_valid_reg;
    logic [7:0] out_c0_reg, out_c1_reg, out_c2_reg;
    logic       out_fe_reg;

    logic raw, colour;
    logic pix_acc, cfg_acc, out_load;

    // current position of the accepted word
    logic [COL_W-1:0]  cur_col, col_inc;
    logic [ROW_W-1:0]  cur_row, row_inc;
    logic [FACT_W-1:0] cur_mc, cur_mr;
    logic [COL_W-1:0]  cur_qc;
    logic [ROW_W-1:0]  cur_qr;
    logic [COL_W:0]    cur_x;
    logic [ROW_W:0]    cur_y;
    logic              cur_hit, cur_first, cur_last, cur_fe;
    logic [ACC_AW-1:0] cur_idx;

    // RAM
    logic              ram_we;
    logic [ACC_W-1:0]  ram_wdata, ram_rdata;
    logic [SUM_W-1:0]  new_sum [3];

    // divider
    div_req_t div_req;
    div_rsp_t div_rsp;

    // setup arithmetic
    logic [DIV_W-1:0]  fact_q;
    logic [FACT_W-1:0] fact_clamped;
    logic [COL_W-1:0]  ow_min, ow_cap;
    logic [COL_W-2:0]  owr_min, owr_cap;
    logic [ROW_W-1:0]  oh_min;
    logic [ROW_W-2:0]  ohr_min;

    assign raw    = (mode_reg == MODE_RAW);
    assign colour = (mode_reg == MODE_COLOR);

    assign pix_in.ready = (state_reg == ST_IDLE) && !cfg.valid;
    assign cfg.ready    = (state_reg == ST_IDLE);
    assign pix_acc      = pix_in.valid && pix_in.ready;
    assign cfg_acc      = cfg.valid && cfg.ready;
    assign out_load     = (state_reg == ST_OUT) && (!out_valid_reg || res_out.ready);

    // ---------------- position of the incoming word ----------------
    always_comb
    begin
        cur_col = pix_in.frame_start ? '0 : col_reg;
        cur_row = pix_in.frame_start ? '0 : row_reg;
        cur_mc  = pix_in.frame_start ? '0 : mc_reg;
        cur_mr  = pix_in.frame_start ? '0 : mr_reg;
        cur_qc  = pix_in.frame_start ? '0 : qc_reg;
        cur_qr  = pix_in.frame_start ? '0 : qr_reg;
        // raw mode interleaves parity into the output coordinate
        cur_x = raw ? {cur_qc, cur_col[0]} : {1'b0, cur_qc};
        cur_y = raw ? {cur_qr, cur_row[0]} : {1'b0, cur_qr};
        cur_hit   = (cur_x < {1'b0, owe_reg}) && (cur_y < {1'b0, ohe_reg});
        cur_first = (cur_mc == '0) && (cur_mr == '0);
        cur_last  = (cur_mc == fw_reg - 1'b1) && (cur_mr == fh_reg - 1'b1);
        cur_fe    = (cur_x == {1'b0, owe_reg} - 1'b1) && (cur_y == {1'b0, ohe_reg} - 1'b1);
        cur_idx   = raw ? {cur_row[0], cur_x[ACC_AW-2:0]} : {1'b0, cur_x[ACC_AW-2:0]};

        // next position
        col_inc  = cur_col + 1'b1;
        row_inc  = cur_row + 1'b1;
        col_next = col_inc;
        row_next = cur_row;
        mc_next  = cur_mc;
        qc_next  = cur_qc;
        mr_next  = cur_mr;
        qr_next  = cur_qr;
        if (col_inc >= sw_reg)
        begin
            col_next = '0;
            mc_next  = '0;
            qc_next  = '0;
            if (row_inc >= sh_reg)
            begin
                row_next = '0;
                mr_next  = '0;
                qr_next  = '0;
            end
            else
            begin
                row_next = row_inc;
                if (!raw || cur_row[0])
                begin
                    if (cur_mr == fh_reg - 1'b1)
                    begin
                        mr_next = '0;
                        qr_next = cur_qr + 1'b1;
                    end
                    else
                    begin
                        mr_next = cur_mr + 1'b1;
                    end
                end
            end
        end
        else if (!raw || cur_col[0])
        begin
            if (cur_mc == fw_reg - 1'b1)
            begin
                mc_next = '0;
                qc_next = cur_qc + 1'b1;
            end
            else
            begin
                mc_next = cur_mc + 1'b1;
            end
        end
    end

    // ---------------- accumulator RAM ----------------
    always_comb
    begin
        for (int n = 0; n < 3; n++)
        begin
            if (n == 0 || colour)
            begin
                new_sum[n] = first_reg ? {8'd0, pix_reg[n]}
                                       : ram_rdata[n*SUM_W +: SUM_W] + {8'd0, pix_reg[n]};
            end
            else
            begin
                new_sum[n] = ram_rdata[n*SUM_W +: SUM_W];
            end
        end
        ram_wdata = {new_sum[2], new_sum[1], new_sum[0]};
        ram_we    = (state_reg == ST_RMW) && hit_reg;
    end

    bad_ram #(
        .WIDTH (ACC_W),
        .DEPTH (ACC_DEPTH)
    ) u_acc (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (ram_wdata),
        .raddr (cur_idx),
        .rdata (ram_rdata)
    );

    // ---------------- divider operands ----------------
    always_comb
    begin
        div_req.start    = (state_reg == ST_SETUP_GO) || (state_reg == ST_DIV_GO);
        div_req.dividend = '0;
        div_req.divisor  = '0;
        if (state_reg == ST_DIV_GO || state_reg == ST_DIV_WAIT)
        begin
            div_req.dividend = sum_reg[ch_reg];
            div_req.divisor  = {7'd0, area_reg};
        end
        else
        begin
            case (step_reg)
                STEP_FW:
                begin
                    div_req.dividend = {5'd0, sw_reg};
                    div_req.divisor  = {5'd0, ow_reg};
                end
                STEP_FH:
                begin
                    div_req.dividend = {3'd0, sh_reg};
                    div_req.divisor  = {3'd0, oh_reg};
                end
                STEP_DW:
                begin
                    div_req.dividend = {5'd0, sw_reg};
                    div_req.divisor  = {11'd0, fw_reg};
                end
                STEP_DH:
                begin
                    div_req.dividend = {3'd0, sh_reg};
                    div_req.divisor  = {11'd0, fh_reg};
                end
                STEP_COL:
                begin
                    div_req.dividend = raw ? {6'd0, col_reg[COL_W-1:1]} : {5'd0, col_reg};
                    div_req.divisor  = {11'd0, fw_reg};
                end
                STEP_ROW:
                begin
                    div_req.dividend = raw ? {4'd0, row_reg[ROW_W-1:1]} : {3'd0, row_reg};
                    div_req.divisor  = {11'd0, fh_reg};
                end
                default:
                begin
                    div_req.dividend = '0;
                    div_req.divisor  = '0;
                end
            endcase
        end
    end

    bad_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // factor clamp to 1..MAX_FACTOR; zero divisor gives 1
    assign fact_q = div_rsp.quot;
    always_comb
    begin
        if (div_req.divisor == '0 || fact_q == '0)
        begin
            fact_clamped = FACT_W'(1);
        end
        else if (fact_q > DIV_W'(MAX_FACTOR))
        begin
            fact_clamped = FACT_W'(MAX_FACTOR);
        end
        else
        begin
            fact_clamped = fact_q[FACT_W-1:0];
        end
    end

    // covered output size
    always_comb
    begin
        ow_min  = (ow_reg < dw_reg) ? ow_reg : dw_reg;
        ow_cap  = (ow_min > COL_W'(MAX_OUT_W)) ? COL_W'(MAX_OUT_W) : ow_min;
        owr_min = (ow_reg[COL_W-1:1] < dw_reg[COL_W-1:1]) ? ow_reg[COL_W-1:1]
                                                          : dw_reg[COL_W-1:1];
        owr_cap = (owr_min > (COL_W-1)'(MAX_OUT_W / 2)) ? (COL_W-1)'(MAX_OUT_W / 2) : owr_min;
        oh_min  = (oh_reg < dh_reg) ? oh_reg : dh_reg;
        ohr_min = (oh_reg[ROW_W-1:1] < dh_reg[ROW_W-1:1]) ? oh_reg[ROW_W-1:1]
                                                          : dh_reg[ROW_W-1:1];
    end

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_SETUP_GO:   state_next = ST_SETUP_WAIT;
            ST_SETUP_WAIT:
            begin
                if (div_rsp.done)
                begin
                    state_next = (step_reg == STEP_ROW) ? ST_SETUP_FIN : ST_SETUP_GO;
                end
            end
            ST_SETUP_FIN:  state_next = ST_IDLE;
            ST_IDLE:
            begin
                if (cfg_acc)
                begin
                    state_next = ST_SETUP_GO;
                end
                else if (pix_acc)
                begin
                    state_next = ST_RMW;
                end
            end
            ST_RMW:        state_next = (hit_reg && last_reg) ? ST_DIV_GO : ST_IDLE;
            ST_DIV_GO:     state_next = ST_DIV_WAIT;
            ST_DIV_WAIT:
            begin
                if (div_rsp.done)
                begin
                    state_next = (colour && ch_reg != 2'd2) ? ST_DIV_GO : ST_OUT;
                end
            end
            ST_OUT:        state_next = out_load ? ST_IDLE : ST_OUT;
            default:       state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_SETUP_GO;
            step_reg      <= STEP_FW;
            sw_reg        <= COL_W'(320);
            sh_reg        <= ROW_W'(240);
            ow_reg        <= COL_W'(320);
            oh_reg        <= ROW_W'(240);
            mode_reg      <= MODE_COLOR;
            col_reg       <= '0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_acc)
            begin
                step_reg <= STEP_FW;
                case (cfg.index)
                    REG_SRC_W:  sw_reg   <= cfg.data[COL_W-1:0];
                    REG_SRC_H:  sh_reg   <= cfg.data;
                    REG_OUT_W:  ow_reg   <= cfg.data[COL_W-1:0];
                    REG_OUT_H:  oh_reg   <= cfg.data;
                    REG_FORMAT: mode_reg <= cfg.data[1:0];
                    default:    ;
                endcase
            end
            else if (state_reg == ST_SETUP_WAIT && div_rsp.done)
            begin
                step_reg <= step_reg + 1'b1;
            end
            if (pix_acc)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_SETUP_WAIT && div_rsp.done)
        begin
            case (step_reg)
                STEP_FW:  fw_reg <= fact_clamped;
                STEP_FH:  fh_reg <= fact_clamped;
                STEP_DW:  dw_reg <= div_rsp.quot[COL_W-1:0];
                STEP_DH:  dh_reg <= div_rsp.quot[ROW_W-1:0];
                STEP_COL:
                begin
                    qc_reg <= div_rsp.quot[COL_W-1:0];
                    mc_reg <= div_rsp.rem[FACT_W-1:0];
                end
                STEP_ROW:
                begin
                    qr_reg <= div_rsp.quot[ROW_W-1:0];
                    mr_reg <= div_rsp.rem[FACT_W-1:0];
                end
                default: ;
            endcase
        end
        if (state_reg == ST_SETUP_FIN)
        begin
            owe_reg  <= raw ? {owr_cap, 1'b0} : ow_cap;
            ohe_reg  <= raw ? {ohr_min, 1'b0} : oh_min;
            area_reg <= {4'd0, fw_reg} * {4'd0, fh_reg};
        end
        if (pix_acc)
        begin
            mc_reg     <= mc_next;
            qc_reg     <= qc_next;
            mr_reg     <= mr_next;
            qr_reg     <= qr_next;
            pix_reg[0] <= pix_in.pixel_c0;
            pix_reg[1] <= pix_in.pixel_c1;
            pix_reg[2] <= pix_in.pixel_c2;
            first_reg  <= cur_first;
            last_reg   <= cur_last;
            hit_reg    <= cur_hit;
            fe_reg     <= cur_fe;
            idx_reg    <= cur_idx;
        end
        if (state_reg == ST_RMW)
        begin
            sum_reg[0] <= new_sum[0];
            sum_reg[1] <= new_sum[1];
            sum_reg[2] <= new_sum[2];
            ch_reg     <= 2'd0;
        end
        if (state_reg == ST_DIV_WAIT && div_rsp.done)
        begin
            q_reg[ch_reg] <= div_rsp.quot[7:0];
            ch_reg        <= ch_reg + 1'b1;
        end
        if (out_load)
        begin
            out_c0_reg <= q_reg[0];
            out_c1_reg <= colour ? q_reg[1] : 8'd0;
            out_c2_reg <= colour ? q_reg[2] : 8'd0;
            out_fe_reg <= fe_reg;
        end
    end

    assign res_out.valid     = out_valid_reg;
    assign res_out.out_c0    = out_c0_reg;
    assign res_out.out_c1    = out_c1_reg;
    assign res_out.out_c2    = out_c2_reg;
    assign res_out.frame_end = out_fe_reg;

endmodule

// ===== rtl/bad_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bad_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bad_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/bad_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bad_div: restoring divider, one quotient bit per cycle
// Start pulse in, done pulse with quotient and remainder once the last quotient bit is in.
// ----------------------------------------------------------------------------
module bad_div import bad_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [DIV_W-1:0]         rem_reg;
    logic [DIV_W-1:0]         quo_reg;
    logic [DIV_W-1:0]         dvs_reg;
    logic [$clog2(DIV_W):0]   cnt_reg;
    logic                     busy_reg;
    logic                     done_reg;
    logic [DIV_W:0]           shifted;
    logic [DIV_W:0]           trial;

    assign shifted = {rem_reg, quo_reg[DIV_W-1]};
    assign trial   = shifted - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= ($clog2(DIV_W) + 1)'(DIV_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == ($clog2(DIV_W) + 1)'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            quo_reg <= req.dividend;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            if (!trial[DIV_W])
            begin
                rem_reg <= trial[DIV_W-1:0];
                quo_reg <= {quo_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[DIV_W-1:0];
                quo_reg <= {quo_reg[DIV_W-2:0], 1'b0};
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quo_reg;
    assign rsp.rem  = rem_reg;

endmodule

// ===== bench/tb_bad_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bad_if: bench-side notes for the downscaler stream interfaces
// The block's own interface file supplies bad_pix_if, bad_res_if, bad_cfg_if.
// ----------------------------------------------------------------------------
package tb_bad_types;
    typedef struct packed {
        logic [7:0] c0;
        logic [7:0] c1;
        logic [7:0] c2;
        logic       fend;
    } ds_result_t;
endpackage

// ===== bench/tb_block_average_image_downscaler_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_block_average_image_downscaler_core: self-checking bench of the decimator
// Streams source frames under several sizes and modes, predicts each averaged
// word with a bench-side box filter, and checks the result stream in order.
// ----------------------------------------------------------------------------
module tb_block_average_image_downscaler_core;
    import bad_pkg::*;
    import tb_bad_types::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    always #5 clk = ~clk;

    bad_pix_if pix_in ();
    bad_res_if res_out ();
    bad_cfg_if cfg ();

    block_average_image_downscaler_core u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .pix_in  (pix_in.sink),
        .res_out (res_out.source),
        .cfg     (cfg.sink)
    );

    // bench copy of the registers and the running position
    int unsigned src_w, src_h, dst_w, dst_h;
    logic [1:0]  fmt;
    int unsigned col_pos, row_pos;
    int unsigned col_sums [2*MAX_OUT_W][3];

    ds_result_t  expected_words[$];
    int          mismatches = 0;
    int          idle_cycles = 0;
    bit          hold_off = 1'b0;
    int          quiet_run = 0;  // nonzero removes gaps for a back-to-back run
    int unsigned words_accepted = 0;

    localparam int WATCHDOG = 20000;

    function automatic int unsigned clamp_factor(int unsigned s, int unsigned d);
        int unsigned f;
        f = (d != 0) ? s / d : 0;
        if (f < 1) f = 1;
        if (f > MAX_FACTOR) f = MAX_FACTOR;
        return f;
    endfunction

    function automatic int unsigned umin(int unsigned a, int unsigned b);
        return (a < b) ? a : b;
    endfunction

    // box-filter predictor: folds one source word into the column sums
    function automatic void average_pixel(logic [7:0] p0, logic [7:0] p1, logic [7:0] p2,
                                          logic fs);
        int unsigned v[3];
        int unsigned fw, fh, ow, oh, x, y, mc, lr, idx, nch;
        bit          is_raw;
        ds_result_t  w;
        v[0] = p0; v[1] = p1; v[2] = p2;
        if (fs)
        begin
            col_pos = 0;
            row_pos = 0;
        end
        is_raw = (fmt == MODE_RAW);
        fw = clamp_factor(src_w, dst_w);
        fh = clamp_factor(src_h, dst_h);
        if (is_raw)
        begin
            ow  = 2 * umin(umin(dst_w / 2, src_w / (2 * fw)), MAX_OUT_W / 2);
            oh  = 2 * umin(dst_h / 2, src_h / (2 * fh));
            mc  = (col_pos >> 1) % fw;
            x   = 2 * ((col_pos >> 1) / fw) + (col_pos & 1);
            lr  = (row_pos >> 1) % fh;
            y   = 2 * ((row_pos >> 1) / fh) + (row_pos & 1);
            idx = x + (row_pos & 1) * MAX_OUT_W;
            nch = 1;
        end
        else
        begin
            ow  = umin(umin(dst_w, src_w / fw), MAX_OUT_W);
            oh  = umin(dst_h, src_h / fh);
            mc  = col_pos % fw;
            x   = col_pos / fw;
            lr  = row_pos % fh;
            y   = row_pos / fh;
            idx = x;
            nch = (fmt == MODE_COLOR) ? 3 : 1;
        end
        if (x < ow && y < oh && idx < 2 * MAX_OUT_W)
        begin
            for (int n = 0; n < nch; n++)
                col_sums[idx][n] = (mc == 0 && lr == 0) ? v[n] : col_sums[idx][n] + v[n];
            if (mc == fw - 1 && lr == fh - 1)
            begin
                w.c0   = 8'(col_sums[idx][0] / (fw * fh));
                w.c1   = (nch > 1) ? 8'(col_sums[idx][1] / (fw * fh)) : 8'd0;
                w.c2   = (nch > 2) ? 8'(col_sums[idx][2] / (fw * fh)) : 8'd0;
                w.fend = (x == ow - 1 && y == oh - 1);
                expected_words.push_back(w);
            end
        end
        col_pos++;
        if (col_pos >= src_w)
        begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= src_h) row_pos = 0;
        end
    endfunction

    // no gap in half the draws or in a quiet run, else mostly short gaps, a few long ones
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_run != 0 || r < 50) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // ---------------- result checker ----------------
    always @(posedge clk)
    begin
        ds_result_t got, exp_w;
        if (rst_n && res_out.valid && res_out.ready)
        begin
            got = {res_out.out_c0, res_out.out_c1, res_out.out_c2, res_out.frame_end};
            if (expected_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word %h", got);
            end
            else
            begin
                exp_w = expected_words.pop_front();
                if (got !== exp_w)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: expected c0=%0d c1=%0d c2=%0d fe=%0d,",
                                  " got c0=%0d c1=%0d c2=%0d fe=%0d"},
                                 exp_w.c0, exp_w.c1, exp_w.c2, exp_w.fend,
                                 got.c0, got.c1, got.c2, got.fend);
                end
            end
        end
    end

    // ---------------- receiver ready, with random and forced stalls ----------------
    initial
    begin
        int g;
        res_out.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off)
                res_out.ready <= 1'b0;
            else
            begin
                g = gap_len();
                if (g == 0)
                    res_out.ready <= 1'b1;
                else
                begin
                    res_out.ready <= 1'b0;
                    repeat (g - 1) @(negedge clk);
                end
            end
        end
    end

    // ---------------- watchdog on accepted words ----------------
    always @(posedge clk)
    begin
        if ((pix_in.valid && pix_in.ready) || (res_out.valid && res_out.ready)
            || (cfg.valid && cfg.ready) || hold_off)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG)
        begin
            $display("block_average_image_downscaler_core verification failed");
            $finish;
        end
    end

    // ---------------- drivers ----------------
    // valid stays high after a word when the next follows with no gap
    task automatic send_pixel(logic [7:0] p0, logic [7:0] p1, logic [7:0] p2, logic fs);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            pix_in.valid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        pix_in.pixel_c0    <= p0;
        pix_in.pixel_c1    <= p1;
        pix_in.pixel_c2    <= p2;
        pix_in.frame_start <= fs;
        pix_in.valid       <= 1'b1;
        @(posedge clk);
        while (!pix_in.ready) @(posedge clk);
        average_pixel(p0, p1, p2, fs);
        words_accepted++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        pix_in.valid <= 1'b0;
        while (expected_words.size() != 0) @(negedge clk);
        // a word that produces no result may still be in its read-modify-write
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, int unsigned val);
        @(negedge clk);
        cfg.index <= idx;
        cfg.data  <= 13'(val);
        cfg.valid <= 1'b1;
        @(posedge clk);
        while (!cfg.ready) @(posedge clk);
        case (idx)
            REG_SRC_W:  src_w = val & 11'h7FF;
            REG_SRC_H:  src_h = val & 13'h1FFF;
            REG_OUT_W:  dst_w = val & 11'h7FF;
            REG_OUT_H:  dst_h = val & 13'h1FFF;
            REG_FORMAT: fmt   = 2'(val);
            default: ;
        endcase
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    // new geometry starts a fresh frame so no unwritten column is read
    task automatic set_geometry(int unsigned sw, int unsigned sh, int unsigned dw,
                                int unsigned dh, logic [1:0] mode);
        wait_drained();
        write_reg(REG_SRC_W, sw);
        write_reg(REG_SRC_H, sh);
        write_reg(REG_OUT_W, dw);
        write_reg(REG_OUT_H, dh);
        write_reg(REG_FORMAT, mode);
    endtask

    task automatic send_frame(int unsigned count, bit well_formed);
        logic fs;
        for (int i = 0; i < count; i++)
        begin
            fs = (i == 0) ? 1'b1 : 1'b0;
            if (!well_formed && $urandom_range(0, 40) == 0) fs = 1'b1;
            send_pixel(8'($urandom), 8'($urandom), 8'($urandom), fs);
        end
    endtask

    // ---------------- tests ----------------
    task automatic test_extremes();
        // extreme values in colour mode with factor 2x2
        set_geometry(4, 2, 2, 1, MODE_COLOR);
        send_pixel(8'hFF, 8'h00, 8'hFF, 1'b1);
        send_pixel(8'hFF, 8'h00, 8'h00, 1'b0);
        send_pixel(8'h00, 8'hFF, 8'h55, 1'b0);
        send_pixel(8'h00, 8'hFF, 8'hAA, 1'b0);
        send_pixel(8'hFF, 8'h00, 8'hFF, 1'b0);
        send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_pixel(8'hFE, 8'h01, 8'h7F, 1'b0);
    endtask

    task automatic test_modes();
        // grey, raw, and the unused mode code, which acts as grey
        set_geometry(4, 2, 2, 2, MODE_GREY);
        send_frame(8, 1);
        set_geometry(4, 4, 2, 2, MODE_RAW);
        send_frame(16, 1);
        set_geometry(3, 2, 3, 2, 2'd3);
        send_frame(6, 1);
    endtask

    task automatic test_odd_sizes();
        // output larger than source, zero output size, odd raw size with
        // uncovered pixels, position wrap without frame_start
        set_geometry(2, 2, 5, 5, MODE_COLOR);
        send_frame(4, 1);
        send_pixel(8'd9, 8'd9, 8'd9, 1'b0);
        set_geometry(3, 2, 0, 0, MODE_COLOR);
        send_frame(6, 1);
        set_geometry(5, 4, 3, 3, MODE_RAW);
        send_frame(20, 1);
    endtask

    task automatic test_max_factor();
        // factor clamps to 16 along a single row, then a full 1024-wide row at factor 1
        set_geometry(20, 1, 1, 1, MODE_GREY);
        send_frame(20, 1);
        set_geometry(1024, 1, 1024, 1, MODE_COLOR);
        send_frame(1024, 1);
    endtask

    task automatic test_backpressure();
        // receiver stalls long while the sender keeps offering pixels
        set_geometry(8, 2, 8, 2, MODE_GREY);
        fork
            begin
                hold_off = 1'b1;
                repeat (400) @(negedge clk);
                hold_off = 1'b0;
            end
            send_frame(16, 1);
        join
        // then the sender pauses until every result has drained
        wait_drained();
        send_frame(16, 1);
    endtask

    task automatic test_random();
        int unsigned sw, sh, dw, dh, total, nf;
        logic [1:0] mode;
        total = 0;
        while (total < 150)
        begin
            mode = 2'($urandom_range(0, 3));
            sw = $urandom_range(1, 12);
            sh = $urandom_range(1, 8);
            dw = $urandom_range(0, 6);
            dh = $urandom_range(0, 6);
            set_geometry(sw, sh, dw, dh, mode);
            quiet_run = ($urandom_range(0, 4) == 0);
            nf = $urandom_range(1, 3);
            for (int f = 0; f < nf; f++)
            begin
                send_frame(sw * sh, $urandom_range(0, 5) != 0);
                total += sw * sh;
            end
            quiet_run = 0;
        end
        // large register values once, so upper data bits toggle
        set_geometry(1024, 4096, 1024, 4096, MODE_GREY);
        send_frame(2, 1);
        set_geometry(1, 3, 2047, 8191, MODE_COLOR);
        send_frame(3, 1);
    endtask

    initial
    begin
        pix_in.valid = 1'b0;
        pix_in.pixel_c0 = '0;
        pix_in.pixel_c1 = '0;
        pix_in.pixel_c2 = '0;
        pix_in.frame_start = 1'b0;
        cfg.valid = 1'b0;
        cfg.index = '0;
        cfg.data = '0;
        src_w = 320; src_h = 240; dst_w = 320; dst_h = 240; fmt = MODE_COLOR;
        col_pos = 0; row_pos = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_extremes();
        test_modes();
        test_odd_sizes();
        test_max_factor();
        test_backpressure();
        test_random();

        pix_in.valid <= 1'b0;
        while (expected_words.size() != 0) @(negedge clk);
        repeat (100) @(negedge clk);
        if (mismatches == 0 && expected_words.size() == 0)
            $display("block_average_image_downscaler_core verification clean");
        else
            $display("block_average_image_downscaler_core verification failed");
        $finish;
    end
endmodule

// ===== files.f =====
rtl/bad_pkg.sv
rtl/bad_if.sv
rtl/bad_ram.sv
rtl/bad_div.sv
rtl/block_average_image_downscaler_core.sv
bench/tb_bad_if.sv
bench/tb_block_average_image_downscaler_core.sv
